FILE: rtl/bba_pkg.sv
package bba_pkg;

    localparam int NUM_BLOCKS_DEF  = 8192;
    localparam int BLOCK_BYTES_DEF = 1024;
    localparam int HEAP_BASE_DEF   = 8388608;

    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;
    localparam int ADDR_W     = 24;
    localparam int KB_W       = 14;
    localparam int FUNC_W     = 2;
    localparam int DVD_W      = 25;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] size_bytes;
        logic [ADDR_W-1:0] address;
    } command_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] alloc_address;
        logic [KB_W-1:0]   total_kb;
        logic [KB_W-1:0]   free_kb;
        logic [KB_W-1:0]   used_kb;
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_BITS,
        ST_FREE_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_REPORT
    } state_t;

endpackage

FILE: rtl/bitmap_block_allocator.sv
// First-fit contiguous block allocator over a bitmap of used blocks.
// Command channel: present cmd with start high; the transaction is taken at
// a clock edge where start is high and busy is low; cmd.func selects
// allocate, free or status. One transaction is in flight at a time.
// Result channel: result is shown for one cycle with done high; the receiver
// cannot stall, so it must take the transaction in that cycle.
// Sequence after acceptance:
//   status or unused func: straight to the report.
//   allocate: a divide rounds the size up to blocks, then the scan steps
//     over a fully used bitmap word, counts a fully free word whole and
//     searches a mixed word bit by bit; the run is marked word by word.
//     A zero or oversized request fails after the divide.
//   free: a divide finds the block, the run table is checked, then the run
//     is cleared word by word; it fails when the address is below the heap,
//     off a block start or past the heap, or holds no run.
// The bitmap and the run table are synchronous memories with one read and
// one write port; the scan reads one 32-bit bitmap word per cycle while
// words are fully free or fully used. After reset the block clears both
// memories with busy high, and the heap then starts out empty.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF,
    parameter int HEAP_BASE   = bba_pkg::HEAP_BASE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bba_pkg::command_t cmd,
    output logic              done,
    output bba_pkg::result_t  result
);

    localparam int WB        = bba_pkg::WORD_BITS;
    localparam int WS        = bba_pkg::WORD_SHIFT;
    localparam int AW        = bba_pkg::ADDR_W;
    localparam int KW        = bba_pkg::KB_W;
    localparam int QUO_W     = bba_pkg::DVD_W;
    localparam int REM_W     = $clog2(BLOCK_BYTES);
    localparam int NUM_WORDS = (NUM_BLOCKS + WB - 1) / WB;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIDX_W    = WIDX_W + WS;
    localparam int IDX_W     = $clog2(NUM_BLOCKS);
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int RUNX_W    = CNT_W + WS + 1;
    localparam int BB_W      = $clog2(BLOCK_BYTES + 1);
    localparam int APROD_W   = BIDX_W + BB_W;
    localparam int KPROD_W   = (CNT_W + BB_W > 24) ? (CNT_W + BB_W) : 24;
    localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WB;
    localparam logic [WB-1:0] PAD_MASK =
        (LAST_BITS == WB) ? '0 : ~((WB'(1) << LAST_BITS) - WB'(1));
    localparam longint TOTAL_BYTES = longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES);
    localparam logic [KW-1:0] TOTAL_KB = KW'(TOTAL_BYTES / 1024);
    localparam logic [AW-1:0] BASE24   = AW'(HEAP_BASE);
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NUM_WORDS - 1);
    localparam logic [IDX_W-1:0]  LAST_BLK  = IDX_W'(NUM_BLOCKS - 1);

    bba_pkg::state_t  state_reg;
    bba_pkg::state_t  state_next;
    logic [IDX_W-1:0]  clr_reg;
    logic [IDX_W-1:0]  clr_next;
    logic [WIDX_W-1:0] word_reg;
    logic [WIDX_W-1:0] word_next;
    logic [WS-1:0]     bit_reg;
    logic [WS-1:0]     bit_next;
    logic [WB-1:0]     bits_reg;
    logic [WB-1:0]     bits_next;
    logic [CNT_W-1:0]  run_reg;
    logic [CNT_W-1:0]  run_next;
    logic [BIDX_W-1:0] start_reg;
    logic [BIDX_W-1:0] start_next;
    logic [CNT_W-1:0]  need_reg;
    logic [CNT_W-1:0]  need_next;
    logic [WIDX_W-1:0] mark_reg;
    logic [WIDX_W-1:0] mark_next;
    logic              op_free_reg;
    logic              op_free_next;
    logic              ok_reg;
    logic              ok_next;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  used_next;
    logic              done_reg;
    logic              done_next;
    bba_pkg::result_t  result_reg;
    bba_pkg::result_t  result_next;

    logic [WB-1:0]     map_mem [NUM_WORDS];
    logic [WB-1:0]     map_rdata_reg;
    logic              map_we;
    logic [WIDX_W-1:0] map_waddr;
    logic [WB-1:0]     map_wdata;
    logic [WIDX_W-1:0] map_raddr;

    logic [CNT_W:0]    run_mem [NUM_BLOCKS];
    logic [CNT_W:0]    run_rdata_reg;
    logic              run_we;
    logic [IDX_W-1:0]  run_waddr;
    logic [CNT_W:0]    run_wdata;
    logic [IDX_W-1:0]  run_raddr;

    logic              div_start;
    logic [QUO_W-1:0]  div_dividend;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic [REM_W-1:0]  div_rem;

    logic [WB-1:0]     scan_word;
    logic              found;
    logic              adv;
    logic [BIDX_W-1:0] end_blk;
    logic [WS-1:0]     lo;
    logic [WS-1:0]     hi;
    logic [WB-1:0]     mask;
    logic [APROD_W-1:0] addr_prod;
    logic [KPROD_W-1:0] used_prod;
    logic [KPROD_W-1:0] free_prod;

    bba_div #(
        .DIVIDEND_W (QUO_W),
        .DIVISOR    (BLOCK_BYTES)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign scan_word = map_rdata_reg | ((word_reg == LAST_WORD) ? PAD_MASK : '0);
    assign end_blk   = BIDX_W'({1'b0, start_reg} + (BIDX_W+1)'(need_reg) - (BIDX_W+1)'(1));
    assign lo        = (mark_reg == start_reg[BIDX_W-1:WS]) ? start_reg[WS-1:0] : '0;
    assign hi        = (mark_reg == end_blk[BIDX_W-1:WS]) ? end_blk[WS-1:0] : WS'(WB - 1);
    assign mask      = ({WB{1'b1}} << lo) & ({WB{1'b1}} >> (WS'(WB - 1) - hi));
    assign addr_prod = APROD_W'(start_reg) * APROD_W'(BLOCK_BYTES);
    assign used_prod = KPROD_W'(used_reg) * KPROD_W'(BLOCK_BYTES);
    assign free_prod = KPROD_W'(CNT_W'(NUM_BLOCKS) - used_reg) * KPROD_W'(BLOCK_BYTES);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        word_next    = word_reg;
        bit_next     = bit_reg;
        bits_next    = bits_reg;
        run_next     = run_reg;
        start_next   = start_reg;
        need_next    = need_reg;
        mark_next    = mark_reg;
        op_free_next = op_free_reg;
        ok_next      = ok_reg;
        addr_next    = addr_reg;
        used_next    = used_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        map_we       = 1'b0;
        map_waddr    = mark_reg;
        map_wdata    = '0;
        map_raddr    = mark_reg;
        run_we       = 1'b0;
        run_waddr    = IDX_W'(start_reg);
        run_wdata    = '0;
        run_raddr    = IDX_W'(start_reg);
        div_start    = 1'b0;
        div_dividend = QUO_W'(cmd.size_bytes) + QUO_W'(BLOCK_BYTES - 1);
        found        = 1'b0;
        adv          = 1'b0;

        case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                map_we    = 32'(clr_reg) < NUM_WORDS;
                map_waddr = WIDX_W'(clr_reg);
                run_we    = 1'b1;
                run_waddr = clr_reg;
                if (clr_reg == LAST_BLK)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end

            bba_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ok_next      = 1'b0;
                    addr_next    = '0;
                    op_free_next = cmd.func == bba_pkg::FUNC_FREE;
                    case (cmd.func)
                        bba_pkg::FUNC_ALLOC:
                        begin
                            div_start  = 1'b1;
                            state_next = bba_pkg::ST_DIV;
                        end
                        bba_pkg::FUNC_FREE:
                        begin
                            if (cmd.address < BASE24)
                            begin
                                state_next = bba_pkg::ST_REPORT;
                            end
                            else
                            begin
                                div_start    = 1'b1;
                                div_dividend = QUO_W'(cmd.address - BASE24);
                                state_next   = bba_pkg::ST_DIV;
                            end
                        end
                        bba_pkg::FUNC_STATUS:
                        begin
                            ok_next    = 1'b1;
                            state_next = bba_pkg::ST_REPORT;
                        end
                        default:
                        begin
                            state_next = bba_pkg::ST_REPORT;
                        end
                    endcase
                end
            end

            bba_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (op_free_reg)
                    begin
                        if (div_rem != '0 || div_quo >= QUO_W'(NUM_BLOCKS))
                        begin
                            state_next = bba_pkg::ST_REPORT;
                        end
                        else
                        begin
                            start_next = BIDX_W'(div_quo);
                            run_raddr  = IDX_W'(div_quo);
                            state_next = bba_pkg::ST_FREE_CHK;
                        end
                    end
                    else
                    begin
                        if (div_quo == '0 || div_quo > QUO_W'(NUM_BLOCKS))
                        begin
                            state_next = bba_pkg::ST_REPORT;
                        end
                        else
                        begin
                            need_next  = CNT_W'(div_quo);
                            run_next   = '0;
                            word_next  = '0;
                            map_raddr  = '0;
                            state_next = bba_pkg::ST_SCAN;
                        end
                    end
                end
            end

            bba_pkg::ST_SCAN:
            begin
                if (&scan_word)
                begin
                    run_next = '0;
                    adv      = 1'b1;
                end
                else if (scan_word == '0)
                begin
                    if (run_reg == '0)
                    begin
                        start_next = {word_reg, WS'(0)};
                    end
                    if (RUNX_W'(run_reg) + RUNX_W'(WB) >= RUNX_W'(need_reg))
                    begin
                        found = 1'b1;
                    end
                    else
                    begin
                        run_next = run_reg + CNT_W'(WB);
                        adv      = 1'b1;
                    end
                end
                else
                begin
                    bits_next  = scan_word;
                    bit_next   = '0;
                    state_next = bba_pkg::ST_BITS;
                end
            end

            bba_pkg::ST_BITS:
            begin
                if (bits_reg[bit_reg])
                begin
                    run_next = '0;
                end
                else
                begin
                    if (run_reg == '0)
                    begin
                        start_next = {word_reg, bit_reg};
                    end
                    run_next = run_reg + CNT_W'(1);
                    if (run_reg + CNT_W'(1) == need_reg)
                    begin
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    if (bit_reg == WS'(WB - 1))
                    begin
                        adv = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_reg + WS'(1);
                    end
                end
            end

            bba_pkg::ST_FREE_CHK:
            begin
                if (run_rdata_reg[CNT_W])
                begin
                    need_next  = run_rdata_reg[CNT_W-1:0];
                    run_we     = 1'b1;
                    mark_next  = start_reg[BIDX_W-1:WS];
                    state_next = bba_pkg::ST_MARK_RD;
                end
                else
                begin
                    state_next = bba_pkg::ST_REPORT;
                end
            end

            bba_pkg::ST_MARK_RD:
            begin
                state_next = bba_pkg::ST_MARK_WR;
            end

            bba_pkg::ST_MARK_WR:
            begin
                map_we    = 1'b1;
                map_wdata = op_free_reg ? (map_rdata_reg & ~mask) : (map_rdata_reg | mask);
                if (mark_reg == end_blk[BIDX_W-1:WS])
                begin
                    ok_next    = 1'b1;
                    state_next = bba_pkg::ST_REPORT;
                    if (op_free_reg)
                    begin
                        used_next = used_reg - need_reg;
                    end
                    else
                    begin
                        used_next = used_reg + need_reg;
                        run_we    = 1'b1;
                        run_wdata = {1'b1, need_reg};
                        addr_next = BASE24 + AW'(addr_prod);
                    end
                end
                else
                begin
                    mark_next  = mark_reg + WIDX_W'(1);
                    state_next = bba_pkg::ST_MARK_RD;
                end
            end

            bba_pkg::ST_REPORT:
            begin
                result_next.ok            = ok_reg;
                result_next.alloc_address = addr_reg;
                result_next.total_kb      = TOTAL_KB;
                result_next.free_kb       = free_prod[10 +: KW];
                result_next.used_kb       = used_prod[10 +: KW];
                done_next                 = 1'b1;
                state_next                = bba_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase

        if (found)
        begin
            mark_next  = start_next[BIDX_W-1:WS];
            state_next = bba_pkg::ST_MARK_RD;
        end
        else if (adv)
        begin
            if (word_reg == LAST_WORD)
            begin
                state_next = bba_pkg::ST_REPORT;
            end
            else
            begin
                word_next  = word_reg + WIDX_W'(1);
                map_raddr  = word_reg + WIDX_W'(1);
                state_next = bba_pkg::ST_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bba_pkg::ST_CLEAR;
            clr_reg     <= '0;
            used_reg    <= '0;
            done_reg    <= 1'b0;
            op_free_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            used_reg    <= used_next;
            done_reg    <= done_next;
            op_free_reg <= op_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        bit_reg    <= bit_next;
        bits_reg   <= bits_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        need_reg   <= need_next;
        mark_reg   <= mark_next;
        ok_reg     <= ok_next;
        addr_reg   <= addr_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (run_we)
        begin
            run_mem[run_waddr] <= run_wdata;
        end
        run_rdata_reg <= run_mem[run_raddr];
    end

    assign busy   = state_reg != bba_pkg::ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/bba_div.sv
module bba_div #(
    parameter int DIVIDEND_W = bba_pkg::DVD_W,
    parameter int DIVISOR    = bba_pkg::BLOCK_BYTES_DEF,
    localparam int REM_W     = $clog2(DIVISOR)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [REM_W-1:0]      remainder
);

    localparam int RECIP_W = DIVIDEND_W - REM_W + 1;
    localparam int PROD_W  = DIVIDEND_W + RECIP_W;
    localparam int BACK_W  = RECIP_W + REM_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((longint'(1) << DIVIDEND_W) / longint'(DIVISOR));
    localparam logic [REM_W:0] DIV_R = (REM_W+1)'(DIVISOR);

    logic                  mul_vld_reg;
    logic                  est_vld_reg;
    logic                  done_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic [RECIP_W-1:0]    est_reg;
    logic [RECIP_W-1:0]    est_next;
    logic [DIVIDEND_W-1:0] back_reg;
    logic [DIVIDEND_W-1:0] back_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [REM_W:0]        part;
    logic                  ge;

    assign prod_next = PROD_W'(dividend) * PROD_W'(RECIP);
    assign est_next  = prod_reg[PROD_W-1 -: RECIP_W];
    assign back_next = DIVIDEND_W'(BACK_W'(est_next) * BACK_W'(DIVISOR));
    assign part      = (REM_W+1)'(dvd_reg - back_reg);
    assign ge        = part >= DIV_R;
    assign quo_next  = DIVIDEND_W'(est_reg) + DIVIDEND_W'(ge);
    assign rem_next  = ge ? REM_W'(part - DIV_R) : REM_W'(part);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            est_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= start;
            est_vld_reg <= mul_vld_reg;
            done_reg    <= est_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            prod_reg <= prod_next;
        end
        if (mul_vld_reg)
        begin
            est_reg  <= est_next;
            back_reg <= back_next;
        end
        if (est_vld_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/bba_checker.sv
module bba_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input bba_pkg::result_t result
);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done shown while busy");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.alloc_address == '0))
        else $error("failed transaction carries an address");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: test/bitmap_block_allocator_check.sv
module bitmap_block_allocator_check
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int HEAP_BASE   = HEAP_BASE_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  command_t cmd,
    input  logic     done,
    input  result_t  result,
    output int       mismatches,
    output int       awaiting
);

    localparam int RUN_W = $clog2(NUM_BLOCKS + 1);

    bit             block_used [NUM_BLOCKS];
    bit             run_live   [NUM_BLOCKS];
    logic [RUN_W-1:0] run_blocks [NUM_BLOCKS];
    int             used_blocks;
    int             replies_seen;
    result_t        heap_reports [$];

    function automatic result_t heap_outcome(command_t c);
        result_t r;
        int      need;
        int      run;
        int      first;
        int      b;
        int      blk;
        longint  off;
        r = '0;
        if (c.func == FUNC_ALLOC)
        begin
            if (c.size_bytes != '0)
            begin
                need  = (int'(c.size_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
                run   = 0;
                first = 0;
                if (need <= NUM_BLOCKS)
                begin
                    for (b = 0; b < NUM_BLOCKS && run < need; b++)
                    begin
                        if (block_used[b])
                            run = 0;
                        else
                        begin
                            if (run == 0)
                                first = b;
                            run++;
                        end
                    end
                    if (run == need)
                    begin
                        for (b = first; b < first + need; b++)
                            block_used[b] = 1'b1;
                        run_blocks[first] = RUN_W'(need);
                        run_live[first]   = 1'b1;
                        used_blocks      += need;
                        r.ok              = 1'b1;
                        r.alloc_address   = ADDR_W'(longint'(HEAP_BASE)
                                                    + longint'(first) * BLOCK_BYTES);
                    end
                end
            end
        end
        else if (c.func == FUNC_FREE)
        begin
            off = longint'(c.address) - HEAP_BASE;
            if (off >= 0 && off % BLOCK_BYTES == 0 && off / BLOCK_BYTES < NUM_BLOCKS)
            begin
                blk = int'(off / BLOCK_BYTES);
                if (run_live[blk])
                begin
                    for (b = blk; b < blk + int'(run_blocks[blk]) && b < NUM_BLOCKS; b++)
                        block_used[b] = 1'b0;
                    used_blocks  -= int'(run_blocks[blk]);
                    run_live[blk] = 1'b0;
                    r.ok          = 1'b1;
                end
            end
        end
        else if (c.func == FUNC_STATUS)
            r.ok = 1'b1;
        r.total_kb = KB_W'(longint'(NUM_BLOCKS) * BLOCK_BYTES / 1024);
        r.free_kb  = KB_W'((longint'(NUM_BLOCKS) - used_blocks) * BLOCK_BYTES / 1024);
        r.used_kb  = KB_W'(longint'(used_blocks) * BLOCK_BYTES / 1024);
        return r;
    endfunction

    task automatic check_field(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        if (got !== want)
        begin
            if (mismatches < 10)
                $display("result %0d: %s expected %0h, got %0h", replies_seen, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        int      b;
        if (!rst_n)
        begin
            for (b = 0; b < NUM_BLOCKS; b++)
            begin
                block_used[b] = 1'b0;
                run_live[b]   = 1'b0;
            end
            used_blocks  = 0;
            replies_seen = 0;
            mismatches   = 0;
            heap_reports.delete();
            awaiting <= 0;
        end
        else
        begin
            if (done)
            begin
                if (heap_reports.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("result %0d: no transaction pending", replies_seen);
                    mismatches++;
                end
                else
                begin
                    want = heap_reports.pop_front();
                    check_field("ok", ADDR_W'(want.ok), ADDR_W'(result.ok));
                    check_field("alloc_address", want.alloc_address, result.alloc_address);
                    check_field("total_kb", ADDR_W'(want.total_kb), ADDR_W'(result.total_kb));
                    check_field("free_kb", ADDR_W'(want.free_kb), ADDR_W'(result.free_kb));
                    check_field("used_kb", ADDR_W'(want.used_kb), ADDR_W'(result.used_kb));
                end
                replies_seen++;
            end
            if (start && !busy)
                heap_reports.push_back(heap_outcome(cmd));
            awaiting <= heap_reports.size();
        end
    end

endmodule

FILE: test/bitmap_block_allocator_test.sv
module bitmap_block_allocator_test;
    import bba_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam logic [ADDR_W-1:0] BASE       = ADDR_W'(HEAP_BASE_DEF);
    localparam int                BLK        = BLOCK_BYTES_DEF;
    localparam int                HEAP_BYTES = NUM_BLOCKS_DEF * BLOCK_BYTES_DEF;
    localparam int                RANDOM_COMMANDS = 1625;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    command_t cmd;
    result_t  result;
    int       mismatches;
    int       awaiting;
    int       burst_left;

    logic [ADDR_W-1:0] live_runs [$];
    logic [ADDR_W-1:0] released  [$];

    bitmap_block_allocator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    bitmap_block_allocator_check watcher (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done && result.ok && result.alloc_address != '0)
            live_runs.push_back(result.alloc_address);
    end

    function automatic command_t make_cmd(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] s,
                                          logic [ADDR_W-1:0] a);
        command_t c;
        c.func       = f;
        c.size_bytes = s;
        c.address    = a;
        return c;
    endfunction

    task automatic issue(command_t c);
        int gap;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaiting != 0);
    endtask

    initial
    begin
        int                n;
        int                pick;
        int                idx;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] target;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        cmd        <= '0;
        burst_left  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        issue(make_cmd(FUNC_STATUS, '0, '0));
        issue(make_cmd(FUNC_ALLOC, '0, '1));
        issue(make_cmd(FUNC_ALLOC, 24'd1, '0));
        issue(make_cmd(FUNC_ALLOC, ADDR_W'(BLK), '0));
        issue(make_cmd(FUNC_ALLOC, ADDR_W'(BLK + 1), '0));
        issue(make_cmd(FUNC_ALLOC, '1, '0));
        issue(make_cmd(FUNC_ALLOC, ADDR_W'(HEAP_BYTES), '0));
        issue(make_cmd(FUNC_FREE, '0, BASE + ADDR_W'(3 * BLK)));
        issue(make_cmd(FUNC_FREE, '1, BASE + ADDR_W'(BLK)));
        issue(make_cmd(FUNC_FREE, '0, BASE + ADDR_W'(BLK)));
        issue(make_cmd(FUNC_ALLOC, ADDR_W'(2 * BLK), '0));
        issue(make_cmd(FUNC_ALLOC, 24'd700, '0));
        issue(make_cmd(FUNC_FREE, '0, '0));
        issue(make_cmd(FUNC_FREE, '0, BASE + 24'd1));
        issue(make_cmd(FUNC_FREE, '0, '1));
        issue(make_cmd(FUNC_FREE, '0, BASE + ADDR_W'((NUM_BLOCKS_DEF - 1) * BLK)));
        issue(make_cmd(FUNC_SPARE, '1, '1));
        issue(make_cmd(FUNC_FREE, '0, BASE));
        issue(make_cmd(FUNC_FREE, '0, BASE + ADDR_W'(BLK)));
        issue(make_cmd(FUNC_FREE, '0, BASE + ADDR_W'(2 * BLK)));
        issue(make_cmd(FUNC_FREE, '0, BASE + ADDR_W'(4 * BLK)));
        issue(make_cmd(FUNC_ALLOC, ADDR_W'(HEAP_BYTES), '0));
        issue(make_cmd(FUNC_ALLOC, 24'd1, '0));
        issue(make_cmd(FUNC_STATUS, '1, '1));
        issue(make_cmd(FUNC_FREE, '0, BASE));
        drain();
        live_runs.delete();

        for (n = 0; n < RANDOM_COMMANDS; n++)
        begin
            if (n == RANDOM_COMMANDS / 2)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 4)
                issue(make_cmd(FUNC_SPARE, ADDR_W'($urandom), ADDR_W'($urandom)));
            else if (pick < 10)
                issue(make_cmd(FUNC_STATUS, ADDR_W'($urandom), ADDR_W'($urandom)));
            else if (live_runs.size() > 0 && (pick < 52 || live_runs.size() > 48))
            begin
                idx    = $urandom_range(0, live_runs.size() - 1);
                target = live_runs[idx];
                pick   = $urandom_range(0, 99);
                if (pick < 85)
                begin
                    live_runs.delete(idx);
                    released.push_back(target);
                    if (released.size() > 16)
                        void'(released.pop_front());
                end
                else if (pick < 90 && released.size() > 0)
                    target = released[$urandom_range(0, released.size() - 1)];
                else if (pick < 94)
                    target = target + ADDR_W'(BLK * $urandom_range(1, 4));
                else if (pick < 97)
                    target = target + ADDR_W'($urandom_range(1, BLK - 1));
                else
                    target = ADDR_W'($urandom);
                issue(make_cmd(FUNC_FREE, ADDR_W'($urandom), target));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    size = '0;
                else if (pick < 55)
                    size = ADDR_W'($urandom_range(1, 4096));
                else if (pick < 75)
                    size = ADDR_W'(BLK * $urandom_range(1, 8));
                else if (pick < 95)
                    size = ADDR_W'($urandom_range(4097, 65536));
                else if (pick < 99)
                    size = ADDR_W'($urandom_range(65537, HEAP_BYTES));
                else
                    size = ADDR_W'($urandom_range(HEAP_BYTES + 1, 16777215));
                issue(make_cmd(FUNC_ALLOC, size, ADDR_W'($urandom)));
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
